// ----- rtl/core/q8dp_pkg.sv -----
// ============================================================================
// q8dp_pkg
// Shared types and constants for the q8 block dot product.
// ============================================================================
package q8dp_pkg;

    localparam int BLOCK_LEN_DEF = 32;   // elements per quantized block
    localparam int WEIGHT_W      = 8;
    localparam int ACT_W         = 16;
    localparam int SCALE_W       = 16;
    localparam int RESULT_W      = 44;
    localparam int MUL_A_W       = 32;   // shared multiplier, wide operand
    localparam int MUL_B_W       = 16;   // shared multiplier, narrow operand
    localparam int PROD_W        = MUL_A_W + MUL_B_W;
    localparam int ELEM_PROD_W   = WEIGHT_W + ACT_W;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_ACC   = 5'b00100,
        S_SCALE = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    // sequencer to datapath controls
    typedef struct packed {
        logic in_ready;     // input register free
        logic mul_en;       // load product register
        logic mul_scale;    // operand select: sum * scale
        logic acc_add;      // add product to running sum
        logic acc_clr;      // clear running sum
        logic out_load;     // load output register
    } t_ctl;

endpackage

// ----- rtl/core/q8dp_if.sv -----
// ============================================================================
// q8dp interfaces
// Valid/ready channels for element requests and block results.
// ============================================================================
interface q8dp_in_if;
    logic               valid;
    logic               ready;
    logic signed [7:0]  weight;
    logic signed [15:0] activation;
    logic signed [15:0] block_scale;

    modport source(output valid, output weight, output activation, output block_scale,
                   input ready);
    modport sink(input valid, input weight, input activation, input block_scale,
                 output ready);
endinterface

interface q8dp_out_if;
    logic               valid;
    logic               ready;
    logic signed [43:0] dot_result;

    modport source(output valid, output dot_result, input ready);
    modport sink(input valid, input dot_result, output ready);
endinterface

// ----- rtl/core/q8dp_mul.sv -----
// ============================================================================
// q8dp_mul
// Shared signed 32x16 multiplier with operand select and product register.
// ============================================================================
module q8dp_mul
    import q8dp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic                      i_sel_scale,
    input  logic signed [WEIGHT_W-1:0] i_weight,
    input  logic signed [ACT_W-1:0]   i_activation,
    input  logic signed [MUL_A_W-1:0] i_sum,
    input  logic signed [SCALE_W-1:0] i_scale,
    output logic signed [PROD_W-1:0]  o_prod
);

    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  n_prod;

    always_comb begin
        if (i_sel_scale) begin
            op_a = i_sum;
            op_b = MUL_B_W'(i_scale);
        end else begin
            op_a = MUL_A_W'(i_activation);
            op_b = MUL_B_W'(i_weight);
        end
        n_prod = PROD_W'(op_a) * PROD_W'(op_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/core/q8dp_fsm.sv -----
// ============================================================================
// q8dp_fsm
// Sequencer: element multiply, accumulate, block scale and result hand-off.
// ============================================================================
module q8dp_fsm
    import q8dp_pkg::*;
#(
    parameter int BLOCK_LEN = BLOCK_LEN_DEF
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_fire,
    input  logic i_out_free,
    output t_ctl o_ctl
);

    localparam int CNT_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             last;

    assign last = (r_cnt == CNT_W'(BLOCK_LEN - 1));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                o_ctl.in_ready = 1'b1;
                if (i_in_fire) n_state = S_MUL;
            end
            S_MUL: begin
                o_ctl.mul_en = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_ctl.acc_add = 1'b1;
                if (last) begin
                    n_cnt   = '0;
                    n_state = S_SCALE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCALE: begin
                // product register takes the old sum, then the sum clears
                o_ctl.mul_en    = 1'b1;
                o_ctl.mul_scale = 1'b1;
                o_ctl.acc_clr   = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- rtl/core/q8_block_dot_product_unit.sv -----
// ============================================================================
// q8_block_dot_product_unit
// Dot product of a q8 block with fixed-point activations, scaled per block.
// ============================================================================
// Usage:
//   i_in carries one element request per handshake: int8 weight, Q8.8
//   activation and a Q4.12 block scale that is used only on the last
//   element of each block of BLOCK_LEN requests.
//   o_out carries one 44-bit result (20 fraction bits) per completed block:
//   the exact sum of weight*activation times the scale, low 44 bits.
// Timing:
//   A single shared 32x16 multiplier serves both the element products and
//   the final scaling. Each element is captured, multiplied and then
//   accumulated before the next one is taken; after the last element of a
//   block the sum is scaled and the result is loaded into the output
//   register.
// Reset: clears the element count, the running sum and the output valid.
// Stall: the result waits in the output register; the next block's elements
//   are still taken, and the unit holds only when a new result is ready while
//   the previous one has not yet been taken.
// ============================================================================
module q8_block_dot_product_unit
    import q8dp_pkg::*;
#(
    parameter int BLOCK_LEN = BLOCK_LEN_DEF
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    q8dp_in_if.sink    i_in,
    q8dp_out_if.source o_out
);

    localparam int SUM_W = ELEM_PROD_W + ((BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 0);

    t_ctl ctl;
    logic in_fire;
    logic out_free;

    logic signed [WEIGHT_W-1:0] r_weight;
    logic signed [ACT_W-1:0]    r_act;
    logic signed [SCALE_W-1:0]  r_scale;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic signed [PROD_W-1:0]   prod;
    logic signed [RESULT_W-1:0] r_result;
    logic                       r_out_valid, n_out_valid;

    assign in_fire    = i_in.valid && ctl.in_ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = ctl.in_ready;

    q8dp_fsm #(.BLOCK_LEN(BLOCK_LEN)) u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_out_free (out_free),
        .o_ctl      (ctl)
    );

    q8dp_mul u_mul (
        .i_clk        (i_clk),
        .i_en         (ctl.mul_en),
        .i_sel_scale  (ctl.mul_scale),
        .i_weight     (r_weight),
        .i_activation (r_act),
        .i_sum        (MUL_A_W'(r_sum)),
        .i_scale      (r_scale),
        .o_prod       (prod)
    );

    always_comb begin
        n_sum = r_sum;
        if (ctl.acc_clr) begin
            n_sum = '0;
        end else if (ctl.acc_add) begin
            n_sum = r_sum + SUM_W'(prod);
        end
        n_out_valid = r_out_valid;
        if (ctl.out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_weight <= i_in.weight;
            r_act    <= i_in.activation;
            r_scale  <= i_in.block_scale;
        end
        if (ctl.out_load) begin
            r_result <= prod[RESULT_W-1:0];
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.dot_result = r_result;

endmodule
